[rtl/leps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect pattern sequencer package
// Shared types, item kinds and the fixed level/duration pattern ROM.
// ----------------------------------------------------------------------------
package leps_pkg;

  localparam int TARGETS_DEF     = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CMD_W    = 2;
  localparam int TARGET_W = 8;
  localparam int EFFECT_W = 3;
  localparam int LEVEL_W  = 2;
  localparam int STEP_W   = 3;
  localparam int TIMER_W  = 8;

  localparam int NUM_PATTERNS = 7;
  localparam int MAX_STEPS    = 6;

  localparam logic [TIMER_W-1:0] TIMER_RESET = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_POST = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_TICK = 2'd2,
    CMD_RSVD = 2'd3
  } leps_cmd_t;

  // Per-channel command, fanned out from the input register.
  typedef struct packed {
    logic                fire;
    leps_cmd_t           cmd;
    logic                sel;
    logic [EFFECT_W-1:0] effect;
    logic                cut_in;
  } leps_chan_cmd_t;

  // Per-channel status, taken after the item has been applied.
  typedef struct packed {
    logic level;
    logic busy;
    logic accept;
  } leps_chan_stat_t;

  // Pattern ROM: bit s of PAT_LEVEL is the level of step s.
  localparam logic [MAX_STEPS-1:0] PAT_LEVEL [NUM_PATTERNS] = '{
    6'b000000, 6'b000001, 6'b000001, 6'b000001, 6'b010101, 6'b000001, 6'b000001
  };

  localparam logic [TIMER_W-1:0] PAT_DUR [NUM_PATTERNS][MAX_STEPS] = '{
    '{8'd10, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0  },
    '{8'd10, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0  },
    '{8'd10, 8'd10, 8'd0,  8'd0,  8'd0,  8'd0  },
    '{8'd10, 8'd10, 8'd0,  8'd0,  8'd0,  8'd0  },
    '{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd200},
    '{8'd30, 8'd30, 8'd0,  8'd0,  8'd0,  8'd0  },
    '{8'd50, 8'd50, 8'd0,  8'd0,  8'd0,  8'd0  }
  };

  localparam logic [STEP_W-1:0] PAT_NSTEPS [NUM_PATTERNS] = '{
    3'd1, 3'd1, 3'd2, 3'd2, 3'd6, 3'd2, 3'd2
  };

  localparam logic PAT_REPEATS [NUM_PATTERNS] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
  };

  localparam logic [STEP_W-1:0] PAT_BACK [NUM_PATTERNS] = '{
    3'd0, 3'd0, 3'd0, 3'd2, 3'd6, 3'd2, 3'd2
  };

  // Map an out-of-range pattern code onto the off pattern.
  function automatic logic [2:0] pat_clamp(input logic [2:0] p);
    pat_clamp = (p >= 3'(NUM_PATTERNS)) ? 3'd0 : p;
  endfunction

  // Map an out-of-range step onto step zero.
  function automatic logic [STEP_W-1:0] step_clamp(input logic [2:0] p,
                                                   input logic [STEP_W-1:0] s);
    step_clamp = (s >= PAT_NSTEPS[p]) ? '0 : s;
  endfunction

  // Step to jump to at a repeat marker.
  function automatic logic [STEP_W-1:0] pat_restart(input logic [2:0] p);
    logic [STEP_W-1:0] s;
    s = (PAT_BACK[p] <= PAT_NSTEPS[p]) ? PAT_NSTEPS[p] - PAT_BACK[p] : '0;
    pat_restart = (s >= PAT_NSTEPS[p]) ? '0 : s;
  endfunction

endpackage

[rtl/leps_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect pattern sequencer: one output channel
// Effect queue, busy mark and pattern step/timer state of one target.
// ----------------------------------------------------------------------------
module leps_chan #(
  parameter int QUEUE_DEPTH = leps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  leps_pkg::leps_chan_cmd_t cmd_i,
  output leps_pkg::leps_chan_stat_t stat_o
);
  import leps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = CW + 1;

  logic [2:0]          pat_r,   pat_nxt;
  logic [STEP_W-1:0]   step_r,  step_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic                busy_r,  busy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [HW-1:0]       head_r,  head_nxt;
  logic [EFFECT_W-1:0] q_r [QUEUE_DEPTH];

  logic                wr_en;
  logic [HW-1:0]       wr_idx;
  logic [CW-1:0]       cnt_v;
  logic [HW-1:0]       head_v;
  logic [SW-1:0]       sum_v;
  logic [EFFECT_W-1:0] pop_e;
  logic [2:0]          cur_p;
  logic [STEP_W-1:0]   cur_s;
  logic [TIMER_W-1:0]  tmr_dec;
  logic [2:0]          nxt_p;
  logic                accept;

  assign pop_e = q_r[head_r];
  assign cur_p = pat_clamp(pat_r);
  assign cur_s = step_clamp(cur_p, step_r);

  always_comb begin
    pat_nxt   = pat_r;
    step_nxt  = step_r;
    timer_nxt = timer_r;
    busy_nxt  = busy_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    wr_en     = 1'b0;
    wr_idx    = head_r;
    accept    = 1'b0;
    cnt_v     = cmd_i.cut_in ? '0 : count_r;
    head_v    = cmd_i.cut_in ? '0 : head_r;
    sum_v     = SW'(head_v) + SW'(cnt_v);
    tmr_dec   = (timer_r != '0) ? timer_r - 1'b1 : '0;
    if (cmd_i.fire) begin
      case (cmd_i.cmd)
        CMD_POST: begin
          if (cmd_i.sel) begin
            if (cmd_i.cut_in) begin
              busy_nxt = 1'b0;
            end
            count_nxt = cnt_v;
            head_nxt  = head_v;
            if (cnt_v < CW'(QUEUE_DEPTH)) begin
              wr_en     = 1'b1;
              wr_idx    = (sum_v >= SW'(QUEUE_DEPTH)) ?
                          HW'(sum_v - SW'(QUEUE_DEPTH)) : HW'(sum_v);
              count_nxt = cnt_v + 1'b1;
              accept    = 1'b1;
            end
          end
        end
        CMD_LOAD: begin
          if (count_r != '0 && !busy_r) begin
            head_nxt  = (head_r == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            busy_nxt  = 1'b1;
            if (pop_e < 3'(NUM_PATTERNS)) begin
              pat_nxt   = pop_e;
              step_nxt  = '0;
              timer_nxt = PAT_DUR[pop_e][0];
            end
          end
        end
        CMD_TICK: begin
          timer_nxt = tmr_dec;
          if (tmr_dec == '0) begin
            if ({1'b0, cur_s} + 1'b1 < {1'b0, PAT_NSTEPS[cur_p]}) begin
              step_nxt  = cur_s + 1'b1;
              timer_nxt = PAT_DUR[cur_p][cur_s + 1'b1];
            end else if (!PAT_REPEATS[cur_p]) begin
              busy_nxt = 1'b0;
            end else begin
              step_nxt  = pat_restart(cur_p);
              timer_nxt = PAT_DUR[cur_p][pat_restart(cur_p)];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign nxt_p         = pat_clamp(pat_nxt);
  assign stat_o.level  = PAT_LEVEL[nxt_p][step_clamp(nxt_p, step_nxt)];
  assign stat_o.busy   = busy_nxt;
  assign stat_o.accept = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      step_r  <= '0;
      timer_r <= TIMER_RESET;
      busy_r  <= 1'b0;
      count_r <= CW'(1);
      head_r  <= '0;
    end else begin
      pat_r   <= pat_nxt;
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  // Queue entries reset to the off effect.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        q_r[i] <= '0;
      end
    end else if (wr_en) begin
      q_r[wr_idx] <= cmd_i.effect;
    end
  end

endmodule

[rtl/led_effect_pattern_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect pattern sequencer, top level
// Per-target effect queues driving fixed blink/level patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer:
//     cmd 0 posts in_effect to in_target's queue (in_cut_in flushes first),
//     cmd 1 starts the oldest queued effect on every idle target,
//     cmd 2 is a timer tick that steps every target's pattern,
//     cmd 3 changes nothing and just reports the current levels.
//   Result channel (out_valid/out_ready) returns exactly one result per
//   item: drive levels and busy flags of targets 0 and 1 after the item,
//   and out_accepted for a post that was stored in its queue.
//   Timing: the item is registered at its input transfer and its result is
//   registered when applied, once the result register is free or drained.
//   Throughput: one item per cycle when not stalled; all per-target work is
//   done in a single pass between the input and result registers.
//   Stall: while out_valid waits on out_ready, one more item is held in the
//   input register and in_ready drops; no item is lost or repeated.
//   Reset: every target plays the off pattern, is idle, and has the off
//   effect queued once; both channels come up empty.
// ----------------------------------------------------------------------------
module led_effect_pattern_sequencer_top #(
  parameter int TARGETS     = leps_pkg::TARGETS_DEF,
  parameter int QUEUE_DEPTH = leps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [leps_pkg::CMD_W-1:0]    in_cmd,
  input  logic [leps_pkg::TARGET_W-1:0] in_target,
  input  logic [leps_pkg::EFFECT_W-1:0] in_effect,
  input  logic                          in_cut_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [leps_pkg::LEVEL_W-1:0]  out_drive_levels,
  output logic [leps_pkg::LEVEL_W-1:0]  out_busy_flags,
  output logic                          out_accepted
);
  import leps_pkg::*;

  // Input register
  logic                in_valid_r;
  leps_cmd_t           cmd_r;
  logic [TARGET_W-1:0] target_r;
  logic [EFFECT_W-1:0] effect_r;
  logic                cut_r;

  // Result register
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  drive_r;
  logic [LEVEL_W-1:0]  busy_fl_r;
  logic                acc_r;

  logic                fire;
  logic                in_xfer;
  leps_chan_cmd_t      chan_cmd [TARGETS];
  leps_chan_stat_t     chan_stat [TARGETS];
  logic [LEVEL_W-1:0]  lv_nxt;
  logic [LEVEL_W-1:0]  bz_nxt;
  logic                acc_nxt;

  // Apply the held item when the result register is free or being drained.
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= leps_cmd_t'(in_cmd);
      target_r <= in_target;
      effect_r <= in_effect;
      cut_r    <= in_cut_in;
    end
  end

  // One channel per target, all stepping in parallel.
  for (genvar t = 0; t < TARGETS; t++) begin : g_chan
    assign chan_cmd[t].fire   = fire;
    assign chan_cmd[t].cmd    = cmd_r;
    assign chan_cmd[t].sel    = (target_r == TARGET_W'(t));
    assign chan_cmd[t].effect = effect_r;
    assign chan_cmd[t].cut_in = cut_r;

    leps_chan #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd_i (chan_cmd[t]),
      .stat_o(chan_stat[t])
    );
  end

  // Gather levels and busy flags of the first two targets; any accept wins.
  always_comb begin
    lv_nxt  = '0;
    bz_nxt  = '0;
    acc_nxt = 1'b0;
    for (int i = 0; i < TARGETS; i++) begin
      if (i < LEVEL_W) begin
        lv_nxt[1'(i)] = chan_stat[i].level;
        bz_nxt[1'(i)] = chan_stat[i].busy;
      end
      acc_nxt = acc_nxt | chan_stat[i].accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r   <= lv_nxt;
      busy_fl_r <= bz_nxt;
      acc_r     <= acc_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_levels = drive_r;
  assign out_busy_flags   = busy_fl_r;
  assign out_accepted     = acc_r;

  // Checks
  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |-> (out_valid_r && !out_ready))
    else $error("held item not applied while result register free");

  a_accept_only_post: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r != CMD_POST) |-> !acc_nxt)
    else $error("accept raised for an item that is not a post");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result produced without a held item");

endmodule

[tb/tb_led_effect_pattern_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LED effect pattern sequencer
// Drives posts, loads, ticks and reserved items through the valid/ready input
// channel. A scoreboard class predicts each result's drive levels, busy flags
// and accept bit from its own copy of the queues and pattern timers. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_led_effect_pattern_sequencer_top;
  import leps_pkg::*;

  // Expected contents of one result transfer.
  typedef struct packed {
    logic [1:0] levels;
    logic [1:0] busy;
    logic       accepted;
  } level_report_t;

  // Scoreboard: own copy of the sequencer state, fed with every accepted
  // item, and the list of results still to arrive.
  class effect_scoreboard;
    // Pattern table: steps, levels (bit s = step s), durations, repeat marker.
    int       rom_nsteps [7] = '{1, 1, 2, 2, 6, 2, 2};
    bit [5:0] rom_level  [7] = '{6'b000000, 6'b000001, 6'b000001, 6'b000001,
                                 6'b010101, 6'b000001, 6'b000001};
    int       rom_dur [7][6] = '{'{10, 0, 0, 0, 0, 0}, '{10, 0, 0, 0, 0, 0},
                                 '{10, 10, 0, 0, 0, 0}, '{10, 10, 0, 0, 0, 0},
                                 '{10, 10, 10, 10, 10, 200},
                                 '{30, 30, 0, 0, 0, 0}, '{50, 50, 0, 0, 0, 0}};
    bit       rom_repeat [7] = '{0, 0, 0, 1, 1, 1, 1};
    int       rom_back   [7] = '{0, 0, 0, 2, 6, 2, 2};

    logic [2:0] pat_sel  [2];
    logic [3:0] step_idx [2];
    logic [7:0] step_tmr [2];
    bit         busy     [2];
    logic [2:0] fifo     [2][4];
    int         fill     [2];
    int         head     [2];

    level_report_t level_queue[$];
    int errors;
    int checked;
    int posts_stored, posts_dropped, loads_started, ticks, ends_seen;

    function new();
      for (int t = 0; t < 2; t++) begin
        pat_sel[t]  = 3'd0;
        step_idx[t] = 4'd0;
        step_tmr[t] = 8'd10;
        busy[t]     = 1'b0;
        for (int i = 0; i < 4; i++) fifo[t][i] = 3'd0;
        fill[t] = 1;
        head[t] = 0;
      end
    endfunction

    function int cur_pattern(int t);
      return (pat_sel[t] >= 7) ? 0 : int'(pat_sel[t]);
    endfunction

    function int cur_step(int t);
      int p;
      p = cur_pattern(t);
      return (step_idx[t] >= rom_nsteps[p]) ? 0 : int'(step_idx[t]);
    endfunction

    function void tick_one(int t);
      int p;
      int s;
      p = cur_pattern(t);
      s = cur_step(t);
      if (step_tmr[t] != 0) step_tmr[t]--;
      if (step_tmr[t] != 0) return;
      if (s + 1 < rom_nsteps[p]) begin
        s++;
      end else if (!rom_repeat[p]) begin
        // end marker: hold the level, drop busy
        if (busy[t]) ends_seen++;
        busy[t] = 1'b0;
        return;
      end else begin
        s = (rom_back[p] <= rom_nsteps[p]) ? rom_nsteps[p] - rom_back[p] : 0;
        if (s >= rom_nsteps[p]) s = 0;
      end
      step_idx[t] = 4'(s);
      step_tmr[t] = 8'(rom_dur[p][s]);
    endfunction

    function void load_one(int t);
      logic [2:0] e;
      if (fill[t] == 0 || busy[t]) return;
      e = fifo[t][head[t] % 4];
      head[t] = (head[t] + 1) % 4;
      fill[t]--;
      busy[t] = 1'b1;
      loads_started++;
      // an unknown effect leaves pattern, step and timer alone
      if (e < 7) begin
        pat_sel[t]  = e;
        step_idx[t] = 4'd0;
        step_tmr[t] = 8'(rom_dur[e][0]);
      end
    endfunction

    function bit post_one(int t, logic [2:0] e, logic cut);
      if (t >= 2) return 1'b0;
      if (cut) begin
        fill[t] = 0;
        head[t] = 0;
        busy[t] = 1'b0;
      end
      if (fill[t] >= 4) return 1'b0;
      fifo[t][(head[t] + fill[t]) % 4] = e;
      fill[t]++;
      return 1'b1;
    endfunction

    // Apply one accepted item and queue the result it must produce.
    function void note_item(leps_cmd_t c, logic [7:0] tg, logic [2:0] ef, logic cut);
      level_report_t r;
      r = '0;
      case (c)
        CMD_POST: begin
          r.accepted = post_one(int'(tg), ef, cut);
          if (r.accepted) posts_stored++;
          else posts_dropped++;
        end
        CMD_LOAD: begin
          for (int t = 0; t < 2; t++) load_one(t);
        end
        CMD_TICK: begin
          ticks++;
          for (int t = 0; t < 2; t++) tick_one(t);
        end
        default: ;
      endcase
      for (int t = 0; t < 2; t++) begin
        r.levels[t] = rom_level[cur_pattern(t)][cur_step(t)];
        r.busy[t]   = busy[t];
      end
      level_queue.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void check_levels(logic [1:0] lv, logic [1:0] bz, logic acc);
      level_report_t w;
      if (level_queue.size() == 0) begin
        report($sformatf("result with nothing expected (lv %b busy %b acc %b)",
                         lv, bz, acc));
        return;
      end
      w = level_queue.pop_front();
      if (lv !== w.levels)
        report($sformatf("result %0d drive_levels %b, want %b", checked, lv, w.levels));
      if (bz !== w.busy)
        report($sformatf("result %0d busy_flags %b, want %b", checked, bz, w.busy));
      if (acc !== w.accepted)
        report($sformatf("result %0d accepted %b, want %b", checked, acc, w.accepted));
      checked++;
    endfunction

    function int pending();
      return level_queue.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  logic [TARGET_W-1:0] in_target;
  logic [EFFECT_W-1:0] in_effect;
  logic                in_cut_in;
  logic                out_valid;
  logic                out_ready;
  logic [LEVEL_W-1:0]  out_drive_levels;
  logic [LEVEL_W-1:0]  out_busy_flags;
  logic                out_accepted;

  effect_scoreboard sb;
  bit steady;      // set: neither side idles
  int items_sent;

  led_effect_pattern_sequencer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_target        (in_target),
    .in_effect        (in_effect),
    .in_cut_in        (in_cut_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_levels (out_drive_levels),
    .out_busy_flags   (out_busy_flags),
    .out_accepted     (out_accepted)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_led_effect_pattern_sequencer_top: done, errors");
    $finish;
  end

  // Receiver: stalls at random, about 28 percent of the time, unless in a steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // Check every result transfer; values read here are the ones the edge saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_levels(out_drive_levels, out_busy_flags, out_accepted);
    end
  end

  // Offer one item, idling first at random, and hold it until the transfer.
  task automatic send_item(input leps_cmd_t c, input logic [7:0] tg,
                           input logic [2:0] ef, input logic cut);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= c;
    in_target <= tg;
    in_effect <= ef;
    in_cut_in <= cut;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c, tg, ef, cut);
    items_sent++;
  endtask

  // Hold the input side until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random post: mostly real targets, sometimes any target code.
  task automatic send_random_post();
    logic [7:0] tg;
    tg = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, 1));
    send_item(CMD_POST, tg, 3'($urandom_range(0, 7)), $urandom_range(0, 99) < 15);
  endtask

  // Any command with fully random payload bits.
  task automatic send_noise();
    send_item(leps_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int n;
    int r;
    sb = new();
    steady     = 1'b0;
    items_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_cmd    <= CMD_RSVD;
    in_target <= '0;
    in_effect <= '0;
    in_cut_in <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset view, off effect queued at reset, each effect
    // code, full queue, bad targets, cut-in flush, unknown effect, ticks.
    send_item(CMD_RSVD, 8'd0,   3'd0, 1'b0);
    send_item(CMD_LOAD, 8'd0,   3'd0, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd1, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd7, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd3, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd4, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd6, 1'b0);   // queue full: dropped
    send_item(CMD_POST, 8'd2,   3'd5, 1'b0);   // first bad target
    send_item(CMD_POST, 8'd255, 3'd0, 1'b1);   // bad target with cut-in
    send_item(CMD_POST, 8'd1,   3'd2, 1'b1);   // flush and clear busy
    send_item(CMD_LOAD, 8'd255, 3'd7, 1'b1);
    send_item(CMD_POST, 8'd0,   3'd5, 1'b1);
    send_item(CMD_LOAD, 8'd0,   3'd0, 1'b0);
    send_item(CMD_POST, 8'd1,   3'd7, 1'b1);
    send_item(CMD_LOAD, 8'd0,   3'd0, 1'b0);   // unknown effect keeps pattern
    repeat (5) send_item(CMD_TICK, 8'd170, 3'd5, 1'b1);
    send_item(CMD_RSVD, 8'd85,  3'd2, 1'b1);
    send_item(CMD_POST, 8'd1,   3'd6, 1'b0);
    send_item(CMD_POST, 8'd0,   3'd0, 1'b0);
    drain_results();

    // Random part: posts, loads and runs of ticks long enough to walk
    // patterns to their ends and repeats, plus some noise.
    n = 0;
    while (n < 1950) begin
      steady = (n >= 600 && n < 900);
      if (n >= 1200 && n < 1210) drain_results();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_random_post();
        n++;
      end else if (r < 37) begin
        send_item(CMD_LOAD, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        n++;
      end else if (r < 42) begin
        send_noise();
        n++;
      end else begin
        repeat ($urandom_range(1, 40)) begin
          send_item(CMD_TICK, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
          n++;
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d items, %0d results: %0d posts stored, %0d dropped,",
             items_sent, sb.checked, sb.posts_stored, sb.posts_dropped);
    $display("  %0d effects started, %0d ticks, %0d patterns run to their end marker.",
             sb.loads_started, sb.ticks, sb.ends_seen);
    if (sb.errors == 0) begin
      $display("tb_led_effect_pattern_sequencer_top: done, clean");
    end else begin
      $display("tb_led_effect_pattern_sequencer_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/leps_pkg.sv
rtl/leps_chan.sv
rtl/led_effect_pattern_sequencer_top.sv
tb/tb_led_effect_pattern_sequencer_top.sv
